>>> sv/iir_transposed_direct_form_two_core_macros.svh
// assertion macros for the transposed direct form two iir core
// used by the port checker, no other dependencies
`ifndef IIR_TRANSPOSED_DIRECT_FORM_TWO_CORE_MACROS_SVH
`define IIR_TRANSPOSED_DIRECT_FORM_TWO_CORE_MACROS_SVH

// checked outside reset
`define IIRTDF2_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define IIRTDF2_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/iirtdf2_pkg.sv
// shared types and constants for the transposed direct form two iir core
// no dependencies
package iirtdf2_pkg;

  localparam int ORDER_DEF     = 4;
  localparam int COEF_FRAC_DEF = 24;

  localparam int CMD_W     = 2;
  localparam int TAP_IDX_W = 5;
  localparam int COEF_W    = 32;
  localparam int SAMPLE_W  = 16;
  localparam int DELAY_W   = 48;
  localparam int PROD_W    = COEF_W + SAMPLE_W;
  localparam int SUM_W     = DELAY_W + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_LOAD_A = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic start;
    logic mul_en;
    logic y_en;
    logic tap_en;
  } mac_ctrl_t;

endpackage

>>> sv/iirtdf2_coef_mem.sv
// coefficient memory: numerator and denominator taps share one word per tap
// depends on iirtdf2_pkg
module iirtdf2_coef_mem #(
  parameter int TAPS = 2 * iirtdf2_pkg::ORDER_DEF + 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   wr_b,
  input  logic                                   wr_a,
  input  logic [$clog2(TAPS)-1:0]                wr_addr,
  input  logic signed [iirtdf2_pkg::COEF_W-1:0]  wr_data,
  input  logic                                   rd_en,
  input  logic [$clog2(TAPS)-1:0]                rd_addr,
  output logic signed [iirtdf2_pkg::COEF_W-1:0]  rd_b,
  output logic signed [iirtdf2_pkg::COEF_W-1:0]  rd_a
);

  localparam int W = iirtdf2_pkg::COEF_W;

  logic [2*W-1:0] mem [TAPS];
  logic [TAPS-1:0] vb;
  logic [TAPS-1:0] va;
  logic [2*W-1:0] rd_q;
  logic            vb_q;
  logic            va_q;

  always_ff @(posedge clk) begin
    if (wr_b) mem[wr_addr][2*W-1:W] <= wr_data;
    if (wr_a) mem[wr_addr][W-1:0] <= wr_data;
    if (rd_en) begin
      rd_q <= mem[rd_addr];
      vb_q <= vb[rd_addr];
      va_q <= va[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
      va <= '0;
    end else begin
      if (wr_b) vb[wr_addr] <= 1'b1;
      if (wr_a) va[wr_addr] <= 1'b1;
    end
  end

  assign rd_b = vb_q ? $signed(rd_q[2*W-1:W]) : '0;
  assign rd_a = va_q ? $signed(rd_q[W-1:0]) : '0;

endmodule

>>> sv/iirtdf2_delay_mem.sv
// delay line memory with per-entry valid bits for reset and clear
// depends on iirtdf2_pkg
module iirtdf2_delay_mem #(
  parameter int TAPS = 2 * iirtdf2_pkg::ORDER_DEF + 1
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    clr,
  input  logic                                    wr_en,
  input  logic [$clog2(TAPS)-1:0]                 wr_addr,
  input  logic signed [iirtdf2_pkg::DELAY_W-1:0]  wr_data,
  input  logic                                    rd_en,
  input  logic [$clog2(TAPS)-1:0]                 rd_addr,
  output logic signed [iirtdf2_pkg::DELAY_W-1:0]  rd_data
);

  logic [iirtdf2_pkg::DELAY_W-1:0] mem [TAPS];
  logic [TAPS-1:0]                 vld;
  logic [iirtdf2_pkg::DELAY_W-1:0] rd_q;
  logic                            vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      vld_q <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = vld_q ? $signed(rd_q) : '0;

endmodule

>>> sv/iirtdf2_mac.sv
// multiply-accumulate datapath: products, output rounding and delay update
// depends on iirtdf2_pkg
module iirtdf2_mac #(
  parameter int COEF_FRAC = iirtdf2_pkg::COEF_FRAC_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  iirtdf2_pkg::mac_ctrl_t                   ctrl,
  input  logic signed [iirtdf2_pkg::SAMPLE_W-1:0]  sample,
  input  logic signed [iirtdf2_pkg::COEF_W-1:0]    coef_b,
  input  logic signed [iirtdf2_pkg::COEF_W-1:0]    coef_a,
  input  logic signed [iirtdf2_pkg::DELAY_W-1:0]   z,
  output logic signed [iirtdf2_pkg::SAMPLE_W-1:0]  y,
  output logic                                     sat,
  output logic signed [iirtdf2_pkg::DELAY_W-1:0]   z_new
);

  localparam int SW = iirtdf2_pkg::SUM_W;
  localparam int DW = iirtdf2_pkg::DELAY_W;
  localparam int XW = iirtdf2_pkg::SAMPLE_W;
  localparam logic signed [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (COEF_FRAC - 1);

  logic signed [XW-1:0]                   x_q;
  logic signed [iirtdf2_pkg::PROD_W-1:0]  prod_b;
  logic signed [iirtdf2_pkg::PROD_W-1:0]  prod_a;
  logic signed [DW-1:0]                   z_q;
  logic signed [SW-1:0]                   acc_y;
  logic signed [SW-1:0]                   y_wide;
  logic signed [SW-1:0]                   v;
  logic                                   y_fits;
  logic                                   v_fits;
  logic signed [XW-1:0]                   y_sat;

  always_ff @(posedge clk) begin
    if (ctrl.start) x_q <= sample;
    if (ctrl.mul_en) begin
      prod_b <= coef_b * x_q;
      prod_a <= coef_a * y;
      z_q    <= z;
    end
    if (ctrl.y_en) y <= y_sat;
  end

  // output: round half up, floor shift, clamp to sample range
  assign acc_y  = SW'(prod_b) + SW'(z_q) + HALF;
  assign y_wide = acc_y >>> COEF_FRAC;
  assign y_fits = (&y_wide[SW-1:XW-1]) | ~(|y_wide[SW-1:XW-1]);
  assign y_sat  = y_fits ? y_wide[XW-1:0]
                : (y_wide[SW-1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}});

  // delay update, clamped to delay width
  assign v      = SW'(prod_b) + SW'(z_q) - SW'(prod_a);
  assign v_fits = (&v[SW-1:DW-1]) | ~(|v[SW-1:DW-1]);
  assign z_new  = v_fits ? v[DW-1:0]
                : (v[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (rst || ctrl.start) begin
      sat <= 1'b0;
    end else if (ctrl.y_en) begin
      sat <= sat | ~y_fits;
    end else if (ctrl.tap_en) begin
      sat <= sat | ~v_fits;
    end
  end

endmodule

>>> sv/iir_transposed_direct_form_two_core.sv
// Transposed direct form two IIR filter core, top level with tap sequencer.
// Depends on iirtdf2_pkg, iirtdf2_coef_mem, iirtdf2_delay_mem, iirtdf2_mac.
//
// Input channel (in_valid / in_stall) carries one command word: sample,
// load numerator tap, load denominator tap, or clear the delay line.
// Loads and clear complete at the accepting edge; the next word is taken
// in the following cycle. A load whose tap_index is past 2*ORDER is dropped.
// A sample walks all 2*ORDER+1 taps through one read-multiply-accumulate
// pipeline around the coefficient and delay memories (one tap per cycle,
// one bubble after tap zero while the output feeds back). in_stall stays
// high from acceptance until the result moves into the output register,
// so a new sample is not taken before the previous one is through.
// Output channel (out_valid / out_stall) is a register: a held result does
// not block the next command, but a finished sample waits in the core
// until the register empties.
// Reset clears all taps and the delay line to zero and empties the output.
// The clear command zeroes the delay line and keeps the coefficients.
module iir_transposed_direct_form_two_core #(
  parameter int ORDER     = iirtdf2_pkg::ORDER_DEF,
  parameter int COEF_FRAC = iirtdf2_pkg::COEF_FRAC_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic [iirtdf2_pkg::CMD_W-1:0]               command,
  input  logic [iirtdf2_pkg::TAP_IDX_W-1:0]           tap_index,
  input  logic signed [iirtdf2_pkg::COEF_W-1:0]       coefficient,
  input  logic signed [iirtdf2_pkg::SAMPLE_W-1:0]     sample,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic signed [iirtdf2_pkg::SAMPLE_W-1:0]     filtered_sample,
  output logic                                        saturated
);

  localparam int TAPS   = 2 * ORDER + 1;
  localparam int ADDR_W = $clog2(TAPS);
  localparam int STEP_W = $clog2(TAPS + 2);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t                                   state;
  logic [STEP_W-1:0]                        step;
  logic                                     m_go;
  logic [ADDR_W-1:0]                        m_idx;
  logic                                     a_go;
  logic [ADDR_W-1:0]                        a_idx;
  iirtdf2_pkg::cmd_t                        cmd;
  logic                                     accept;
  logic                                     tap_ok;
  logic                                     start;
  logic                                     wr_b;
  logic                                     wr_a;
  logic                                     clr;
  logic                                     iss_go;
  logic [ADDR_W-1:0]                        iss_idx;
  iirtdf2_pkg::mac_ctrl_t                   ctrl;
  logic signed [iirtdf2_pkg::COEF_W-1:0]    coef_b;
  logic signed [iirtdf2_pkg::COEF_W-1:0]    coef_a;
  logic signed [iirtdf2_pkg::DELAY_W-1:0]   z_rd;
  logic signed [iirtdf2_pkg::DELAY_W-1:0]   z_new;
  logic signed [iirtdf2_pkg::SAMPLE_W-1:0]  y;
  logic                                     sat;

  assign in_stall = rst || (state != S_IDLE);
  assign cmd      = iirtdf2_pkg::cmd_t'(command);
  assign accept   = in_valid && !in_stall;
  assign tap_ok   = tap_index < iirtdf2_pkg::TAP_IDX_W'(TAPS);
  assign start    = accept && (cmd == iirtdf2_pkg::CMD_SAMPLE);
  assign wr_b     = accept && (cmd == iirtdf2_pkg::CMD_LOAD_B) && tap_ok;
  assign wr_a     = accept && (cmd == iirtdf2_pkg::CMD_LOAD_A) && tap_ok;
  assign clr      = accept && (cmd == iirtdf2_pkg::CMD_CLEAR);

  // tap zero issues on acceptance, taps one and up after a bubble
  assign iss_go  = start || ((state == S_RUN) && (step >= STEP_W'(2))
                             && (step <= STEP_W'(TAPS)));
  assign iss_idx = start ? '0 : ADDR_W'(step - STEP_W'(1));

  assign ctrl.start  = start;
  assign ctrl.mul_en = m_go;
  assign ctrl.y_en   = a_go && (a_idx == '0);
  assign ctrl.tap_en = a_go && (a_idx != '0);

  iirtdf2_coef_mem #(.TAPS(TAPS)) u_coef_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_b    (wr_b),
    .wr_a    (wr_a),
    .wr_addr (tap_index[ADDR_W-1:0]),
    .wr_data (coefficient),
    .rd_en   (iss_go),
    .rd_addr (iss_idx),
    .rd_b    (coef_b),
    .rd_a    (coef_a)
  );

  iirtdf2_delay_mem #(.TAPS(TAPS)) u_delay_mem (
    .clk     (clk),
    .rst     (rst),
    .clr     (clr),
    .wr_en   (ctrl.tap_en),
    .wr_addr (a_idx - ADDR_W'(1)),
    .wr_data (z_new),
    .rd_en   (iss_go),
    .rd_addr (iss_idx),
    .rd_data (z_rd)
  );

  iirtdf2_mac #(.COEF_FRAC(COEF_FRAC)) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (sample),
    .coef_b (coef_b),
    .coef_a (coef_a),
    .z      (z_rd),
    .y      (y),
    .sat    (sat),
    .z_new  (z_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      m_go      <= 1'b0;
      a_go      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      m_go  <= iss_go;
      m_idx <= iss_idx;
      a_go  <= m_go;
      a_idx <= m_idx;
      if (out_valid && !out_stall && (state != S_DONE)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
            step  <= STEP_W'(1);
          end
        end
        S_RUN: begin
          if (step != STEP_W'(TAPS + 1)) step <= step + STEP_W'(1);
          if (a_go && (a_idx == ADDR_W'(TAPS - 1))) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            filtered_sample <= y;
            saturated       <= sat;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/iirtdf2_checker.sv
// port-level checker for the iir core, bound to the top level
// depends on iirtdf2_pkg and the core macros header
`include "iir_transposed_direct_form_two_core_macros.svh"

module iirtdf2_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     in_valid,
  input logic                                     in_stall,
  input logic [iirtdf2_pkg::CMD_W-1:0]            command,
  input logic [iirtdf2_pkg::TAP_IDX_W-1:0]        tap_index,
  input logic signed [iirtdf2_pkg::COEF_W-1:0]    coefficient,
  input logic signed [iirtdf2_pkg::SAMPLE_W-1:0]  sample,
  input logic                                     out_valid,
  input logic                                     out_stall,
  input logic signed [iirtdf2_pkg::SAMPLE_W-1:0]  filtered_sample,
  input logic                                     saturated
);

  logic sample_acc;
  logic other_acc;

  assign sample_acc = in_valid && !in_stall && (command == iirtdf2_pkg::CMD_SAMPLE);
  assign other_acc  = in_valid && !in_stall && (command != iirtdf2_pkg::CMD_SAMPLE);

  `IIRTDF2_ASSERT_ALWAYS(a_reset_empties_out, rst |=> !out_valid, "output valid after reset")

  `IIRTDF2_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(filtered_sample) && $stable(saturated), "stalled output word changed")

  `IIRTDF2_ASSERT(a_sample_busy, sample_acc |=> in_stall, "core took a word while running a sample")

  `IIRTDF2_ASSERT(a_cmd_single_cycle, other_acc |=> !in_stall, "load or clear held the input")

  `IIRTDF2_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(in_stall), "result appeared without a sample in flight")

endmodule

bind iir_transposed_direct_form_two_core iirtdf2_checker u_iirtdf2_checker (.*);

>>> test/testbench.sv
// self-checking testbench for iir_transposed_direct_form_two_core: coefficient loads,
// delay clears and samples against a bit-accurate filter scoreboard
// depends on iirtdf2_pkg and the core rtl
`timescale 1ns / 100ps

module testbench;

  localparam int ORDER = iirtdf2_pkg::ORDER_DEF;
  localparam int COEF_FRAC = iirtdf2_pkg::COEF_FRAC_DEF;
  localparam int SAMPLE_W = iirtdf2_pkg::SAMPLE_W;
  localparam int COEF_W = iirtdf2_pkg::COEF_W;
  localparam int DELAY_W = iirtdf2_pkg::DELAY_W;
  localparam int TAP_IDX_W = iirtdf2_pkg::TAP_IDX_W;
  localparam int TAPS = 2 * ORDER + 1;
  localparam int TOTAL_WORDS = 1120;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AT_WORD = 500;
  localparam int LIMIT_CYCLES = 400000;
  localparam longint SAMPLE_MAX = 32767;
  localparam longint SAMPLE_MIN = -32768;
  localparam longint DELAY_MAX = (longint'(1) <<< (DELAY_W - 1)) - 1;
  localparam longint DELAY_MIN = -(longint'(1) <<< (DELAY_W - 1));

  typedef enum {COEF_FIR, COEF_STABLE, COEF_WILD, COEF_SPARSE} coef_style_t;
  typedef enum {SAMPLES_FULL, SAMPLES_SMALL, SAMPLES_EXTREME} sample_style_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  class iir_filter_scoreboard;
    typedef struct {
      logic signed [SAMPLE_W-1:0] y;
      logic                       sat;
    } filter_out_t;

    logic signed [COEF_W-1:0]  num_taps [TAPS];
    logic signed [COEF_W-1:0]  den_taps [TAPS];
    logic signed [DELAY_W-1:0] delay_line [TAPS];
    filter_out_t pending_outputs [$];
    int mismatches;
    int words_seen;

    function new();
      foreach (num_taps[i]) begin
        num_taps[i] = '0;
        den_taps[i] = '0;
        delay_line[i] = '0;
      end
      mismatches = 0;
      words_seen = 0;
    endfunction

    function filter_out_t filter_sample(logic signed [SAMPLE_W-1:0] x);
      filter_out_t r;
      longint acc;
      longint v;
      r.sat = 1'b0;
      acc = longint'(num_taps[0]) * longint'(x) + longint'(delay_line[0])
            + (longint'(1) <<< (COEF_FRAC - 1));
      acc = acc >>> COEF_FRAC;
      if (acc > SAMPLE_MAX) begin
        acc = SAMPLE_MAX;
        r.sat = 1'b1;
      end else if (acc < SAMPLE_MIN) begin
        acc = SAMPLE_MIN;
        r.sat = 1'b1;
      end
      r.y = acc[SAMPLE_W-1:0];
      for (int i = 1; i < TAPS; i++) begin
        v = longint'(num_taps[i]) * longint'(x) + longint'(delay_line[i])
            - longint'(den_taps[i]) * acc;
        if (v > DELAY_MAX) begin
          v = DELAY_MAX;
          r.sat = 1'b1;
        end else if (v < DELAY_MIN) begin
          v = DELAY_MIN;
          r.sat = 1'b1;
        end
        delay_line[i-1] = v[DELAY_W-1:0];
      end
      delay_line[TAPS-1] = '0;
      return r;
    endfunction

    function void note_word(iirtdf2_pkg::cmd_t c, logic [TAP_IDX_W-1:0] t,
                            logic signed [COEF_W-1:0] k, logic signed [SAMPLE_W-1:0] s);
      words_seen++;
      case (c)
        iirtdf2_pkg::CMD_LOAD_B: if (t < TAPS) num_taps[t] = k;
        iirtdf2_pkg::CMD_LOAD_A: if (t < TAPS) den_taps[t] = k;
        iirtdf2_pkg::CMD_CLEAR: foreach (delay_line[i]) delay_line[i] = '0;
        iirtdf2_pkg::CMD_SAMPLE:
          pending_outputs.insert(pending_outputs.size(), filter_sample(s));
      endcase
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] y, logic sat);
      filter_out_t e;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no sample pending: y %0d sat %0b", $time, y, sat);
        return;
      end
      e = pending_outputs.pop_front();
      if (y !== e.y || sat !== e.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: y exp %0d got %0d, sat exp %0b got %0b",
                   $time, e.y, y, e.sat, sat);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  iirtdf2_pkg::cmd_t command;
  logic [TAP_IDX_W-1:0] tap_index;
  logic signed [COEF_W-1:0] coefficient;
  logic signed [SAMPLE_W-1:0] sample;
  logic out_valid;
  logic out_stall;
  logic signed [SAMPLE_W-1:0] filtered_sample;
  logic saturated;

  iir_filter_scoreboard sb = new();
  int burst_left = 0;
  int cycle_count = 0;

  iir_transposed_direct_form_two_core #(
    .ORDER(ORDER),
    .COEF_FRAC(COEF_FRAC)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .tap_index(tap_index),
    .coefficient(coefficient),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .filtered_sample(filtered_sample),
    .saturated(saturated)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("** iir_transposed_direct_form_two_core: FAILED **");
      $finish;
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(filtered_sample, saturated);
  end

  initial begin
    stall_mode_t mode;
    int mode_left;
    int period;
    int phase;
    bit held;
    mode = STALL_NONE;
    mode_left = 0;
    period = 2;
    phase = 0;
    held = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sb.words_seen >= HOLD_AT_WORD) begin
        // long hold-off so the core backs up into its input
        held = 1;
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(64, 256);
        period = $urandom_range(2, 9);
      end
      mode_left--;
      phase = (phase + 1) % period;
      case (mode)
        STALL_NONE: out_stall = 1'b0;
        STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall = (phase == 0);
      endcase
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(iirtdf2_pkg::cmd_t c, logic [TAP_IDX_W-1:0] t,
                           logic signed [COEF_W-1:0] k, logic signed [SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_valid = 1'b1;
    command = c;
    tap_index = t;
    coefficient = k;
    sample = s;
    do @(posedge clk); while (in_stall);
    sb.note_word(c, t, k, s);
    @(negedge clk);
  endtask

  task automatic load_tap(iirtdf2_pkg::cmd_t c, int idx, logic signed [COEF_W-1:0] k);
    send_word(c, idx[TAP_IDX_W-1:0], k, SAMPLE_W'($urandom));
  endtask

  task automatic push_sample(logic signed [SAMPLE_W-1:0] s);
    send_word(iirtdf2_pkg::CMD_SAMPLE, TAP_IDX_W'($urandom), $urandom, s);
  endtask

  task automatic clear_delay();
    send_word(iirtdf2_pkg::CMD_CLEAR, TAP_IDX_W'($urandom), $urandom,
              SAMPLE_W'($urandom));
  endtask

  function automatic iirtdf2_pkg::cmd_t rand_load_cmd();
    return ($urandom_range(0, 1) == 0) ? iirtdf2_pkg::CMD_LOAD_B : iirtdf2_pkg::CMD_LOAD_A;
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef(coef_style_t st, bit den);
    int span;
    span = 0;
    case (st)
      COEF_FIR: span = den ? 0 : (1 << 23);
      COEF_STABLE: span = den ? (1 << 20) : (1 << 22);
      COEF_WILD: return $urandom;
      COEF_SPARSE: begin
        case ($urandom_range(0, 5))
          0: return 0;
          1: return 1 << COEF_FRAC;
          2: return -(1 << COEF_FRAC);
          3: return 32'h7FFF_FFFF;
          4: return 32'h8000_0000;
          default: return int'($urandom_range(0, 255)) - 128;
        endcase
      end
    endcase
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample(sample_style_t st);
    case (st)
      SAMPLES_SMALL: return SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
      SAMPLES_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return '0;
          3: return 16'sd1;
          default: return -16'sd1;
        endcase
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    coef_style_t cst;
    sample_style_t sst;
    int n;
    rst = 1'b1;
    in_valid = 1'b0;
    command = iirtdf2_pkg::CMD_SAMPLE;
    tap_index = '0;
    coefficient = '0;
    sample = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed words
    push_sample(16'sh7FFF);
    load_tap(iirtdf2_pkg::CMD_LOAD_B, 0, 32'h7FFF_FFFF);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    load_tap(iirtdf2_pkg::CMD_LOAD_B, TAPS - 1, 32'h8000_0000);
    load_tap(iirtdf2_pkg::CMD_LOAD_A, TAPS - 1, 32'h7FFF_FFFF);
    // denominator tap zero is stored but never used
    load_tap(iirtdf2_pkg::CMD_LOAD_A, 0, 32'h1234_5678);
    // out of range tap loads are dropped
    load_tap(iirtdf2_pkg::CMD_LOAD_B, 31, 32'h7FFF_FFFF);
    load_tap(iirtdf2_pkg::CMD_LOAD_A, TAPS, 32'h8000_0000);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    repeat (4) push_sample('0);
    clear_delay();
    push_sample(16'sd1);
    load_tap(iirtdf2_pkg::CMD_LOAD_B, TAPS - 1, 0);
    load_tap(iirtdf2_pkg::CMD_LOAD_A, TAPS - 1, 0);
    // half gain: ties round up
    load_tap(iirtdf2_pkg::CMD_LOAD_B, 0, 1 << (COEF_FRAC - 1));
    push_sample(16'sd1);
    push_sample(-16'sd1);
    push_sample(16'sd3);
    push_sample(-16'sd3);

    while (sb.words_seen < TOTAL_WORDS) begin
      cst = coef_style_t'($urandom_range(0, 3));
      sst = sample_style_t'($urandom_range(0, 2));
      for (int i = 0; i < TAPS; i++) begin
        if ($urandom_range(0, 9) != 0)
          load_tap(iirtdf2_pkg::CMD_LOAD_B, i, rand_coef(cst, 1'b0));
        if ($urandom_range(0, 9) != 0)
          load_tap(iirtdf2_pkg::CMD_LOAD_A, i, rand_coef(cst, 1'b1));
        if ($urandom_range(0, 19) == 0)
          load_tap(rand_load_cmd(), $urandom_range(TAPS, 31), $urandom);
      end
      if ($urandom_range(0, 9) < 7) clear_delay();
      n = $urandom_range(15, 60);
      repeat (n) begin
        case ($urandom_range(0, 39))
          0: clear_delay();
          1: load_tap(rand_load_cmd(), $urandom_range(0, 31),
                      rand_coef(cst, $urandom_range(0, 1)));
          default: push_sample(rand_sample(sst));
        endcase
      end
    end
    in_valid = 1'b0;

    while (sb.pending_outputs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_outputs.size() == 0) begin
      $display("** iir_transposed_direct_form_two_core: PASSED **");
    end else begin
      $display("** iir_transposed_direct_form_two_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> iir_transposed_direct_form_two_core.f
+incdir+sv
sv/iirtdf2_pkg.sv
sv/iirtdf2_coef_mem.sv
sv/iirtdf2_delay_mem.sv
sv/iirtdf2_mac.sv
sv/iir_transposed_direct_form_two_core.sv
sv/iirtdf2_checker.sv
test/testbench.sv
